// ===== sv/spp_pkg.sv =====
package spp_pkg;

   localparam int PAGE_BYTES_DEFAULT = 64;
   localparam int SUM_W = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_FIRST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_THIRD = 2'd2;

   localparam logic [7:0] SIG_FIRST_RESET = 8'd30;
   localparam logic [7:0] SIG_SECOND_RESET = 8'd148;
   localparam logic [7:0] SIG_THIRD_RESET = 8'd6;

   localparam logic [7:0] CH_I = 8'h49;
   localparam logic [7:0] CH_A = 8'h41;
   localparam logic [7:0] CH_W = 8'h57;
   localparam logic [7:0] CH_R = 8'h52;
   localparam logic [7:0] CH_Y = 8'h59;
   localparam logic [7:0] CH_N = 8'h4E;

   typedef enum logic [2:0] {
      ACT_REPLY = 3'd0,
      ACT_ERASE = 3'd1,
      ACT_FILL  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_RESET = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIG,
      PH_ADDR,
      PH_WSUM,
      PH_WDATA
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_FOLD,
      S_FILL_RD,
      S_FILL_OUT,
      S_WRITE,
      S_REPLY,
      S_ERASE,
      S_RST
   } state_type;

   typedef enum logic [1:0] {
      ALU_ACC,
      ALU_FOLD,
      ALU_OFFSET,
      ALU_ADVANCE
   } alu_op_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
   } csr_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W-1:0] sum;
      logic [15:0]      word;
      logic [15:0]      addr;
      logic [15:0]      offset;
   } alu_req_type;

endpackage

// ===== sv/serial_page_programming_command_engine_unit.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_rx_byte
// rsp      out        rsp_valid/rsp_ready    action, reply byte, address, fill word, last
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A request without results is accepted while idle and then decoded.
// A completed page adds up to two folds and then the compare. If the checksum
// matches, each word is filled by a buffer read then an output load, and the
// page write follows; the reply comes last in either case.
// The single shared adder and the registered page buffer read set these steps.
// Reset is synchronous, clears the sequencer and command state, and reloads the
// signature registers; rsp_ready low holds the sequencer at its next result.
module serial_page_programming_command_engine_unit #(
   parameter int PAGE_BYTES = spp_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_action,
   output logic [7:0]                        rsp_reply_byte,
   output logic [15:0]                       rsp_flash_address,
   output logic [15:0]                       rsp_fill_word,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data
);
   import spp_pkg::*;

   localparam int WORDS = (PAGE_BYTES + 1) / 2;
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   csr_type           csr_ff, csr_in;
   alu_req_type       alu_req;
   logic [SUM_W-1:0]  alu_result;
   logic              buf_wr_en;
   logic [WIDX_W-1:0] buf_wr_addr;
   logic [15:0]       buf_wr_data;
   logic              buf_rd_en;
   logic [WIDX_W-1:0] buf_rd_addr;
   logic [15:0]       buf_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SIG_FIRST:  csr_in.first  = csr_data;
            CSR_SIG_SECOND: csr_in.second = csr_data;
            CSR_SIG_THIRD:  csr_in.third  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{first: SIG_FIRST_RESET, second: SIG_SECOND_RESET,
                     third: SIG_THIRD_RESET};
      end else begin
         csr_ff <= csr_in;
      end
   end

   spp_alu #(.PAGE_BYTES(PAGE_BYTES)) u_alu (
      .req    (alu_req),
      .result (alu_result)
   );

   spp_pbuf #(.WORDS(WORDS), .WIDX_W(WIDX_W)) u_pbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   spp_seq #(.PAGE_BYTES(PAGE_BYTES), .WORDS(WORDS), .WIDX_W(WIDX_W)) u_seq (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_flash_address (rsp_flash_address),
      .rsp_fill_word     (rsp_fill_word),
      .rsp_last          (rsp_last),
      .alu_req           (alu_req),
      .alu_result        (alu_result),
      .buf_wr_en         (buf_wr_en),
      .buf_wr_addr       (buf_wr_addr),
      .buf_wr_data       (buf_wr_data),
      .buf_rd_en         (buf_rd_en),
      .buf_rd_addr       (buf_rd_addr),
      .buf_rd_data       (buf_rd_data)
   );

endmodule

// ===== sv/spp_alu.sv =====
module spp_alu #(
   parameter int PAGE_BYTES = spp_pkg::PAGE_BYTES_DEFAULT
) (
   input  spp_pkg::alu_req_type          req,
   output logic [spp_pkg::SUM_W-1:0]     result
);
   import spp_pkg::*;

   logic [SUM_W-1:0] a_op;
   logic [SUM_W-1:0] b_op;

   always_comb begin
      case (req.op)
         ALU_ACC: begin
            a_op = req.sum;
            b_op = {8'd0, req.word};
         end
         ALU_FOLD: begin
            a_op = {8'd0, req.sum[15:0]};
            b_op = {16'd0, req.sum[23:16]};
         end
         ALU_OFFSET: begin
            a_op = {8'd0, req.addr};
            b_op = {8'd0, req.offset};
         end
         ALU_ADVANCE: begin
            a_op = {8'd0, req.addr};
            b_op = SUM_W'(PAGE_BYTES);
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign result = a_op + b_op;

endmodule

// ===== sv/spp_pbuf.sv =====
module spp_pbuf #(
   parameter int WORDS = 32,
   parameter int WIDX_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [WIDX_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [WIDX_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [WORDS];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/spp_seq.sv =====
module spp_seq #(
   parameter int PAGE_BYTES = spp_pkg::PAGE_BYTES_DEFAULT,
   parameter int WORDS = (PAGE_BYTES + 1) / 2,
   parameter int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spp_pkg::csr_type              csr,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_action,
   output logic [7:0]                    rsp_reply_byte,
   output logic [15:0]                   rsp_flash_address,
   output logic [15:0]                   rsp_fill_word,
   output logic                          rsp_last,
   output spp_pkg::alu_req_type          alu_req,
   input  logic [spp_pkg::SUM_W-1:0]     alu_result,
   output logic                          buf_wr_en,
   output logic [WIDX_W-1:0]             buf_wr_addr,
   output logic [15:0]                   buf_wr_data,
   output logic                          buf_rd_en,
   output logic [WIDX_W-1:0]             buf_rd_addr,
   input  logic [15:0]                   buf_rd_data
);
   import spp_pkg::*;

   localparam int CNT_W = ($clog2(PAGE_BYTES) > 2) ? $clog2(PAGE_BYTES) : 2;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      addr_ff, addr_in;
   logic [15:0]      expected_ff, expected_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             mismatch_ff, mismatch_in;
   logic             halted_ff, halted_in;
   logic             fail_ff, fail_in;
   logic [7:0]       byte_ff;
   logic [7:0]       low_ff, low_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [15:0]      fill_addr_ff, fill_addr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   action_type       rsp_action_ff, rsp_action_in;
   logic [7:0]       rsp_reply_ff, rsp_reply_in;
   logic [15:0]      rsp_addr_ff, rsp_addr_in;
   logic [15:0]      rsp_word_ff, rsp_word_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             load_ok;
   logic             rsp_load;
   logic [7:0]       want;
   logic             fold_busy;
   logic             sum_match;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign fold_busy = (sum_ff[23:16] != 8'd0);
   assign sum_match = (sum_ff[15:0] == expected_ff);

   always_comb begin
      case (count_ff[1:0])
         2'd0:    want = csr.first;
         2'd1:    want = csr.second;
         default: want = csr.third;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (!halted_ff) begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (byte_ff == CH_I || byte_ff == CH_A) state_in = S_IDLE;
                     else if (byte_ff == CH_W) state_in = S_ERASE;
                     else if (byte_ff == CH_R) state_in = S_RST;
                     else state_in = S_REPLY;
                  end
                  PH_SIG: begin
                     if (count_ff == CNT_W'(2)) state_in = S_REPLY;
                  end
                  PH_ADDR: begin
                     if (count_ff != '0) state_in = S_REPLY;
                  end
                  PH_WDATA: begin
                     if (count_ff == CNT_W'(PAGE_BYTES - 1)) state_in = S_FOLD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FOLD: begin
            if (!fold_busy) state_in = sum_match ? S_FILL_RD : S_REPLY;
         end
         S_FILL_RD: state_in = S_FILL_OUT;
         S_FILL_OUT: begin
            if (load_ok) begin
               state_in = (widx_ff == WIDX_W'(WORDS - 1)) ? S_WRITE : S_FILL_RD;
            end
         end
         S_WRITE: begin
            if (load_ok) state_in = S_REPLY;
         end
         S_REPLY, S_ERASE, S_RST: begin
            if (load_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      expected_in   = expected_ff;
      sum_in        = sum_ff;
      mismatch_in   = mismatch_ff;
      halted_in     = halted_ff;
      fail_in       = fail_ff;
      low_in        = low_ff;
      widx_in       = widx_ff;
      fill_addr_in  = fill_addr_ff;
      rsp_load      = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_reply_in  = rsp_reply_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      alu_req.op     = ALU_ACC;
      alu_req.sum    = sum_ff;
      alu_req.word   = {byte_ff, low_ff};
      alu_req.addr   = addr_ff;
      alu_req.offset = {{(16 - WIDX_W - 1){1'b0}}, widx_ff, 1'b0};
      buf_wr_en     = 1'b0;
      buf_wr_addr   = WIDX_W'(count_ff >> 1);
      buf_wr_data   = {byte_ff, low_ff};
      buf_rd_en     = 1'b0;
      buf_rd_addr   = widx_ff;

      case (state_ff)
         S_EXEC: begin
            if (!halted_ff) begin
               case (phase_ff)
                  PH_IDLE: begin
                     count_in    = '0;
                     mismatch_in = 1'b0;
                     if (byte_ff == CH_I) phase_in = PH_SIG;
                     else if (byte_ff == CH_A) phase_in = PH_ADDR;
                     else if (byte_ff == CH_W) phase_in = PH_WSUM;
                     else if (byte_ff == CH_R) halted_in = 1'b1;
                     else fail_in = 1'b1;
                  end
                  PH_SIG: begin
                     if (count_ff == CNT_W'(2)) begin
                        fail_in     = mismatch_ff || (byte_ff != want);
                        phase_in    = PH_IDLE;
                        count_in    = '0;
                        mismatch_in = 1'b0;
                     end else begin
                        mismatch_in = mismatch_ff || (byte_ff != want);
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  PH_ADDR: begin
                     if (count_ff == '0) begin
                        addr_in  = {8'd0, byte_ff};
                        count_in = CNT_W'(1);
                     end else begin
                        addr_in  = {byte_ff, addr_ff[7:0]};
                        fail_in  = 1'b0;
                        phase_in = PH_IDLE;
                        count_in = '0;
                     end
                  end
                  PH_WSUM: begin
                     if (count_ff == '0) begin
                        expected_in = {8'd0, byte_ff};
                        count_in    = CNT_W'(1);
                     end else begin
                        expected_in = {byte_ff, expected_ff[7:0]};
                        phase_in    = PH_WDATA;
                        count_in    = '0;
                        sum_in      = '0;
                     end
                  end
                  PH_WDATA: begin
                     low_in   = byte_ff;
                     count_in = count_ff + CNT_W'(1);
                     if (count_ff[0]) begin
                        buf_wr_en = 1'b1;
                        sum_in    = alu_result;
                     end else if (count_ff == CNT_W'(PAGE_BYTES - 1)) begin
                        buf_wr_en   = 1'b1;
                        buf_wr_data = {8'd0, byte_ff};
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         S_FOLD: begin
            alu_req.op = ALU_FOLD;
            if (fold_busy) begin
               sum_in = alu_result;
            end else begin
               fail_in  = !sum_match;
               widx_in  = '0;
               phase_in = PH_IDLE;
               count_in = '0;
               sum_in   = '0;
            end
         end
         S_FILL_RD: begin
            alu_req.op   = ALU_OFFSET;
            buf_rd_en    = 1'b1;
            fill_addr_in = alu_result[15:0];
         end
         S_FILL_OUT: begin
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_action_in = ACT_FILL;
               rsp_reply_in  = 8'd0;
               rsp_addr_in   = fill_addr_ff;
               rsp_word_in   = buf_rd_data;
               rsp_last_in   = 1'b0;
               widx_in       = widx_ff + WIDX_W'(1);
            end
         end
         S_WRITE: begin
            alu_req.op = ALU_ADVANCE;
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_action_in = ACT_WRITE;
               rsp_reply_in  = 8'd0;
               rsp_addr_in   = addr_ff;
               rsp_word_in   = 16'd0;
               rsp_last_in   = 1'b0;
               addr_in       = alu_result[15:0];
               fail_in       = 1'b0;
            end
         end
         S_REPLY: begin
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_action_in = ACT_REPLY;
               rsp_reply_in  = fail_ff ? CH_N : CH_Y;
               rsp_addr_in   = 16'd0;
               rsp_word_in   = 16'd0;
               rsp_last_in   = 1'b1;
            end
         end
         S_ERASE: begin
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_action_in = ACT_ERASE;
               rsp_reply_in  = 8'd0;
               rsp_addr_in   = addr_ff;
               rsp_word_in   = 16'd0;
               rsp_last_in   = 1'b1;
            end
         end
         S_RST: begin
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_action_in = ACT_RESET;
               rsp_reply_in  = 8'd0;
               rsp_addr_in   = 16'd0;
               rsp_word_in   = 16'd0;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         expected_ff  <= '0;
         sum_ff       <= '0;
         mismatch_ff  <= 1'b0;
         halted_ff    <= 1'b0;
         fail_ff      <= 1'b0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         expected_ff  <= expected_in;
         sum_ff       <= sum_in;
         mismatch_ff  <= mismatch_in;
         halted_ff    <= halted_in;
         fail_ff      <= fail_in;
         widx_ff      <= widx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) byte_ff <= req_rx_byte;
      low_ff        <= low_in;
      fill_addr_ff  <= fill_addr_in;
      rsp_action_ff <= rsp_action_in;
      rsp_reply_ff  <= rsp_reply_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_reply_byte    = rsp_reply_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_fill_word     = rsp_word_ff;
   assign rsp_last          = rsp_last_ff;

   a_halt_only_reset: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && rsp_load) |-> (rsp_action_in == ACT_RESET))
      else $error("request after halt produced a result other than the reset request");

   a_halt_phase_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (phase_ff == PH_IDLE))
      else $error("command phase left idle after halt");

   a_fold_in_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD) |-> (phase_ff == PH_WDATA))
      else $error("checksum fold outside the data phase");

   a_fill_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL_OUT) |->
         ($past(state_ff) == S_FILL_RD || $past(state_ff) == S_FILL_OUT))
      else $error("fill emitted without a buffer read");

endmodule
